[hw/rtl/svr_pkg.sv]
// Shared types, constants and constant tables of the sine voice with release tail.
package svr_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int SAMPLE_BITS     = 16;

  localparam int ACTION_W = 2;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int SCALE_W  = 28;
  localparam int AMP_W    = 16;
  localparam int TAIL_W   = 17;
  localparam int FREQ_W   = 24;
  localparam int MAG_W    = SAMPLE_BITS - 1;

  localparam int NOTE_COUNT = 2 ** NOTE_W;
  localparam int VEL_COUNT  = 2 ** VEL_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(22906492);

  // One shared multiplier covers every product of the voice.
  localparam int MUL_A_W = MAG_W + AMP_W;
  localparam int MUL_B_W = TAIL_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int SCALE_HALF_W = SCALE_W / 2;
  localparam int STEP_LO_W    = FREQ_W + SCALE_HALF_W;
  localparam int STEP_SUM_W   = FREQ_W + SCALE_W;
  localparam int STEP_SHIFT   = 18 + 32 - PHASE_BITS;

  localparam int QUARTER        = 2 ** (SINE_TABLE_BITS - 2);
  localparam int SINE_ROM_DEPTH = QUARTER + 1;
  localparam int SINE_IDX_W     = SINE_TABLE_BITS - 1;

  localparam logic [TAIL_W-1:0] TAIL_ONE   = TAIL_W'(65536);
  localparam logic [TAIL_W-1:0] TAIL_DECAY = TAIL_W'(64881);
  localparam logic [TAIL_W-1:0] TAIL_FLOOR = TAIL_W'(328);
  localparam int TAIL_SHIFT  = 16;
  localparam int NOTAIL_SHIFT = 16;
  localparam int WITHTAIL_SHIFT = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_NOTE_ON = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_STOP    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NOTE2,
    ST_NOTE3,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MSEL_SCALE_LO,
    MSEL_SCALE_HI,
    MSEL_MAG_AMP,
    MSEL_TAIL,
    MSEL_DECAY
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     mem_wr;
    logic     out_load;
    logic     sine_load;
    logic     lo_load;
    logic     mag_load;
  } ctrl_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] phase_step;
    logic [AMP_W-1:0]      amplitude;
    logic [TAIL_W-1:0]     tail_gain;
  } voice_state_t;

  typedef logic [MAG_W-1:0]  sine_rom_t [SINE_ROM_DEPTH];
  typedef logic [FREQ_W-1:0] freq_rom_t [NOTE_COUNT];
  typedef logic [AMP_W-1:0]  amp_rom_t  [VEL_COUNT];

  // Top octave (A8 up to G#9) in Q.16 Hz, one entry per semitone from A.
  localparam logic [31:0] TOP_OCTAVE [12] = '{
    32'd461373440, 32'd488808132, 32'd517874176, 32'd548668578,
    32'd581294109, 32'd615859655, 32'd652480576, 32'd691279090,
    32'd732384684, 32'd775934544, 32'd822074013, 32'd870957077
  };

  // Q30 coefficients of sin(pi/2 * u), odd powers 1 through 13.
  localparam logic [63:0] SINE_COEF [7] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
    64'd172272, 64'd3864, 64'd61
  };

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] SAMPLE_FULL = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  // Quarter-wave sine magnitudes, evaluated with the same truncating Horner steps.
  function automatic sine_rom_t sine_rom_f();
    sine_rom_t   rom;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] s;
    for (int p = 0; p < SINE_ROM_DEPTH; p++) begin
      u  = 64'(p) << (32 - SINE_TABLE_BITS);
      u2 = (u * u) >> 30;
      s  = SINE_COEF[6];
      for (int k = 5; k >= 0; k--) begin
        s = SINE_COEF[k] - ((s * u2) >> 30);
      end
      s = (s * u) >> 30;
      if (s > Q30_ONE) begin
        s = Q30_ONE;
      end
      rom[p] = MAG_W'((s * SAMPLE_FULL + (64'd1 << 29)) >> 30);
    end
    return rom;
  endfunction

  // Note frequencies in Q14.10, each a rounded shift of the top octave.
  function automatic freq_rom_t freq_rom_f();
    freq_rom_t   rom;
    int          m;
    int          oct;
    int          sh;
    logic [63:0] v;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      m   = n + 3;
      oct = m / 12;
      sh  = 16 - oct;
      v   = (64'(TOP_OCTAVE[m % 12]) + (64'd1 << (sh - 1))) >> sh;
      rom[n] = FREQ_W'(v);
    end
    return rom;
  endfunction

  // Amplitude round(velocity * 0.15 / 127) in Q0.16.
  function automatic amp_rom_t amp_rom_f();
    amp_rom_t rom;
    for (int v = 0; v < VEL_COUNT; v++) begin
      rom[v] = AMP_W'((64'(v) * 64'd98304 + 64'd635) / 64'd1270);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_rom_f();
  localparam freq_rom_t FREQ_ROM = freq_rom_f();
  localparam amp_rom_t  AMP_ROM  = amp_rom_f();

endpackage

[hw/rtl/svr_state_mem.sv]
// Single-entry voice state memory with a registered read port and a valid bit.
module svr_state_mem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  svr_pkg::voice_state_t  wr_data,
  input  logic                   rd_en,
  output svr_pkg::voice_state_t  rd_data_r
);

  svr_pkg::voice_state_t mem_q [1];
  logic                  valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[0] <= wr_data;
    end
  end

  // An entry never written since reset reads as the all-zero reset state.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r ? mem_q[0] : '0;
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("state memory read and written in the same cycle");

endmodule

[hw/rtl/svr_mul.sv]
// Shared unsigned multiplier with a registered product.
module svr_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [svr_pkg::MUL_A_W-1:0] a,
  input  logic [svr_pkg::MUL_B_W-1:0] b,
  output logic [svr_pkg::PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= svr_pkg::PROD_W'(a) * svr_pkg::PROD_W'(b);
    end
  end

endmodule

[hw/rtl/sine_voice_with_release_decay_unit.sv]
// One sine voice: note on, release tail, stop, and one output sample per tick.
// The voice takes one beat at a time and accepts the next once it is back in idle.
// A tick on a sounding voice steps through the decode, MUL1, MUL2, MUL3 and output states
// and loads its result in the output state; a tick on an idle voice goes from decode
// straight to output, a note on runs through decode, NOTE2 and NOTE3, and a release or
// stop writes back in decode. The sequence is set by the single read-modify-write pass
// over the voice state memory (registered read port) and by the one shared 31x17
// multiplier that forms the sine times amplitude, the tail gain product and the tail
// decay in turn, or the two halves of the phase step product for a note on. A result
// beat waits in an output register; a tick finds its result slot busy only if the
// previous result is still not taken, and then holds in its last cycle.
module sine_voice_with_release_decay_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [svr_pkg::ACTION_W-1:0]       in_action,
  input  logic [svr_pkg::NOTE_W-1:0]         in_note,
  input  logic [svr_pkg::VEL_W-1:0]          in_velocity,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [svr_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                               out_voice_ended,
  output logic                               out_active,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [svr_pkg::SCALE_W-1:0]        cfg_phase_scale
);

  svr_pkg::state_t       state_r;
  svr_pkg::state_t       state_nxt;
  svr_pkg::ctrl_t        ctrl;
  svr_pkg::action_t      action_r;
  svr_pkg::voice_state_t st;
  svr_pkg::voice_state_t wr_state;

  logic [svr_pkg::SCALE_W-1:0]   scale_r;
  logic [svr_pkg::FREQ_W-1:0]    freq_r;
  logic [svr_pkg::AMP_W-1:0]     amp_r;
  logic [svr_pkg::MAG_W-1:0]     sine_mag_r;
  logic                          sine_neg_r;
  logic [svr_pkg::STEP_LO_W-1:0] lo_r;
  logic [svr_pkg::MAG_W-1:0]     mag_r;

  logic                                out_valid_r;
  logic [svr_pkg::SAMPLE_BITS-1:0]     out_sample_r;
  logic                                out_voice_ended_r;
  logic                                out_active_r;

  logic                          in_fire;
  logic                          out_free;
  logic                          tail_run;
  logic                          step_zero;
  logic [svr_pkg::MUL_A_W-1:0]   mul_a;
  logic [svr_pkg::MUL_B_W-1:0]   mul_b;
  logic [svr_pkg::PROD_W-1:0]    prod;

  logic [svr_pkg::SINE_TABLE_BITS-1:0] sine_idx;
  logic [svr_pkg::SINE_IDX_W-1:0]      quarter_pos;
  logic [svr_pkg::SINE_IDX_W-1:0]      rom_idx;

  logic [svr_pkg::STEP_SUM_W-1:0]  step_sum;
  logic [svr_pkg::TAIL_W-1:0]      tail_dec;
  logic                            tail_ends;
  logic [svr_pkg::SAMPLE_BITS-1:0] smp_mag;
  logic [svr_pkg::SAMPLE_BITS-1:0] smp_val;

  assign in_ready  = (state_r == svr_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign tail_run  = (st.tail_gain != '0);
  assign step_zero = (st.phase_step == '0);

  svr_state_mem u_state_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (ctrl.mem_wr),
    .wr_data   (wr_state),
    .rd_en     (in_fire),
    .rd_data_r (st)
  );

  svr_mul u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      svr_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = svr_pkg::ST_DECODE;
      end
      svr_pkg::ST_DECODE: begin
        unique case (action_r)
          svr_pkg::ACT_NOTE_ON: state_nxt = svr_pkg::ST_NOTE2;
          svr_pkg::ACT_TICK:    state_nxt = step_zero ? svr_pkg::ST_OUT : svr_pkg::ST_MUL1;
          svr_pkg::ACT_RELEASE,
          svr_pkg::ACT_STOP:    state_nxt = svr_pkg::ST_IDLE;
        endcase
      end
      svr_pkg::ST_NOTE2: state_nxt = svr_pkg::ST_NOTE3;
      svr_pkg::ST_NOTE3: state_nxt = svr_pkg::ST_IDLE;
      svr_pkg::ST_MUL1:  state_nxt = svr_pkg::ST_MUL2;
      svr_pkg::ST_MUL2:  state_nxt = svr_pkg::ST_MUL3;
      svr_pkg::ST_MUL3:  state_nxt = svr_pkg::ST_OUT;
      svr_pkg::ST_OUT: begin
        if (out_free) state_nxt = svr_pkg::ST_IDLE;
      end
      default: state_nxt = svr_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl         = '0;
    ctrl.mul_sel = svr_pkg::MSEL_SCALE_LO;
    unique case (state_r)
      svr_pkg::ST_IDLE: ;
      svr_pkg::ST_DECODE: begin
        unique case (action_r)
          svr_pkg::ACT_NOTE_ON: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = svr_pkg::MSEL_SCALE_LO;
          end
          svr_pkg::ACT_TICK:    ctrl.sine_load = 1'b1;
          svr_pkg::ACT_RELEASE,
          svr_pkg::ACT_STOP:    ctrl.mem_wr = 1'b1;
        endcase
      end
      svr_pkg::ST_NOTE2: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = svr_pkg::MSEL_SCALE_HI;
        ctrl.lo_load = 1'b1;
      end
      svr_pkg::ST_NOTE3: ctrl.mem_wr = 1'b1;
      svr_pkg::ST_MUL1: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = svr_pkg::MSEL_MAG_AMP;
      end
      svr_pkg::ST_MUL2: begin
        // Without a tail the sine times amplitude product stays in place.
        ctrl.mul_en  = tail_run;
        ctrl.mul_sel = svr_pkg::MSEL_TAIL;
      end
      svr_pkg::ST_MUL3: begin
        ctrl.mag_load = 1'b1;
        ctrl.mul_en   = 1'b1;
        ctrl.mul_sel  = svr_pkg::MSEL_DECAY;
      end
      svr_pkg::ST_OUT: begin
        ctrl.out_load = out_free;
        ctrl.mem_wr   = out_free && !step_zero;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ctrl.mul_sel)
      svr_pkg::MSEL_SCALE_LO: begin
        mul_a = svr_pkg::MUL_A_W'(freq_r);
        mul_b = svr_pkg::MUL_B_W'(scale_r[svr_pkg::SCALE_HALF_W-1:0]);
      end
      svr_pkg::MSEL_SCALE_HI: begin
        mul_a = svr_pkg::MUL_A_W'(freq_r);
        mul_b = svr_pkg::MUL_B_W'(scale_r[svr_pkg::SCALE_W-1:svr_pkg::SCALE_HALF_W]);
      end
      svr_pkg::MSEL_MAG_AMP: begin
        mul_a = svr_pkg::MUL_A_W'(sine_mag_r);
        mul_b = svr_pkg::MUL_B_W'(st.amplitude);
      end
      svr_pkg::MSEL_TAIL: begin
        mul_a = prod[svr_pkg::MUL_A_W-1:0];
        mul_b = st.tail_gain;
      end
      svr_pkg::MSEL_DECAY: begin
        mul_a = svr_pkg::MUL_A_W'(st.tail_gain);
        mul_b = svr_pkg::TAIL_DECAY;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Quarter-wave folding: odd quadrants run the table backward, the upper half negates.
  assign sine_idx    = st.phase[svr_pkg::PHASE_BITS-1 -: svr_pkg::SINE_TABLE_BITS];
  assign quarter_pos = svr_pkg::SINE_IDX_W'(sine_idx[svr_pkg::SINE_TABLE_BITS-3:0]);
  assign rom_idx     = sine_idx[svr_pkg::SINE_TABLE_BITS-2]
                       ? svr_pkg::SINE_IDX_W'(svr_pkg::QUARTER) - quarter_pos
                       : quarter_pos;

  // The high partial product sits in prod, the low one in lo_r.
  assign step_sum = (svr_pkg::STEP_SUM_W'(prod[svr_pkg::STEP_LO_W-1:0])
                     << svr_pkg::SCALE_HALF_W) + svr_pkg::STEP_SUM_W'(lo_r);

  assign tail_dec  = prod[svr_pkg::TAIL_SHIFT +: svr_pkg::TAIL_W];
  assign tail_ends = tail_run && (tail_dec <= svr_pkg::TAIL_FLOOR);
  assign smp_mag   = svr_pkg::SAMPLE_BITS'(mag_r);
  assign smp_val   = sine_neg_r ? (~smp_mag + 1'b1) : smp_mag;

  // Write-back data of the state memory.
  always_comb begin
    wr_state = st;
    case (state_r)
      svr_pkg::ST_DECODE: begin
        if (action_r == svr_pkg::ACT_STOP) begin
          wr_state.phase_step = '0;
          wr_state.amplitude  = '0;
          wr_state.tail_gain  = '0;
        end else if (!step_zero && !tail_run) begin
          wr_state.tail_gain = svr_pkg::TAIL_ONE;
        end
      end
      svr_pkg::ST_NOTE3: begin
        wr_state.phase      = '0;
        wr_state.phase_step = step_sum[svr_pkg::STEP_SHIFT +: svr_pkg::PHASE_BITS];
        wr_state.amplitude  = amp_r;
        wr_state.tail_gain  = '0;
      end
      svr_pkg::ST_OUT: begin
        wr_state.phase = st.phase + st.phase_step;
        if (tail_ends) begin
          wr_state.phase_step = '0;
          wr_state.amplitude  = '0;
          wr_state.tail_gain  = '0;
        end else if (tail_run) begin
          wr_state.tail_gain = tail_dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svr_pkg::ST_IDLE;
      scale_r <= svr_pkg::SCALE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        scale_r <= cfg_phase_scale;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r <= svr_pkg::action_t'(in_action);
      freq_r   <= svr_pkg::FREQ_ROM[in_note];
      amp_r    <= svr_pkg::AMP_ROM[in_velocity];
    end
    if (ctrl.sine_load) begin
      sine_mag_r <= svr_pkg::SINE_ROM[rom_idx];
      sine_neg_r <= sine_idx[svr_pkg::SINE_TABLE_BITS-1];
    end
    if (ctrl.lo_load) begin
      lo_r <= prod[svr_pkg::STEP_LO_W-1:0];
    end
    if (ctrl.mag_load) begin
      mag_r <= tail_run ? prod[svr_pkg::WITHTAIL_SHIFT +: svr_pkg::MAG_W]
                        : prod[svr_pkg::NOTAIL_SHIFT +: svr_pkg::MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_sample_r      <= step_zero ? '0 : smp_val;
      out_voice_ended_r <= tail_ends && !step_zero;
      out_active_r      <= !step_zero && !tail_ends;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_voice_ended = out_voice_ended_r;
  assign out_active      = out_active_r;

  a_end_not_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_voice_ended_r |-> !out_active_r)
    else $error("a finished tail reported the voice as still active");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_active_r && !out_voice_ended_r |-> out_sample_r == '0)
    else $error("an idle voice produced a nonzero sample");

  a_tail_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.mem_wr |-> (wr_state.tail_gain == '0 || wr_state.phase_step != '0))
    else $error("a running tail was written back for an idle voice");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == svr_pkg::ST_OUT))
    else $error("a result beat appeared outside the output step");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the sine voice with release tail, with a transaction-level predictor.
`timescale 1ns / 100ps

module testbench;
  import svr_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_BUDGET = 120;
  localparam int PRINT_CAP    = 50;

  // Frequencies of A8 up to G#9 in Q.16 Hz; lower notes are rounded right shifts.
  localparam logic [31:0] OCTAVE_Q16 [12] = '{
    32'd461373440, 32'd488808132, 32'd517874176, 32'd548668578,
    32'd581294109, 32'd615859655, 32'd652480576, 32'd691279090,
    32'd732384684, 32'd775934544, 32'd822074013, 32'd870957077
  };
  // Odd Taylor-like terms of sin(pi/2 * u) in Q30.
  localparam logic [63:0] SINE_Q30 [7] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
    64'd172272, 64'd3864, 64'd61
  };
  localparam logic [63:0] FULL_TURN_Q30 = 64'd1 << 30;
  localparam logic [63:0] PEAK_CODE     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [TAIL_W-1:0] TAIL_START     = TAIL_W'(65536);
  localparam logic [63:0]       TAIL_FACTOR    = 64'd64881;
  localparam logic [TAIL_W-1:0] TAIL_END_LEVEL = TAIL_W'(328);
  localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;

  typedef struct {
    action_t            action;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   velocity;
  } voice_item_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          ended;
    logic                          active;
    int unsigned                   tick_no;
  } tick_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [ACTION_W-1:0]           in_action = '0;
  logic [NOTE_W-1:0]             in_note = '0;
  logic [VEL_W-1:0]              in_velocity = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_voice_ended;
  logic                          out_active;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [SCALE_W-1:0]            cfg_phase_scale = '0;

  // Predicted voice state and register copy.
  logic [SCALE_W-1:0]    v_scale = SCALE_W'(22906492);
  logic [PHASE_BITS-1:0] v_phase = '0;
  logic [PHASE_BITS-1:0] v_step = '0;
  logic [AMP_W-1:0]      v_amp = '0;
  logic [TAIL_W-1:0]     v_tail = '0;

  voice_item_t  beat_backlog [$];
  tick_result_t owed_ticks [$];
  voice_item_t  next_beat;

  logic in_beat = 1'b0;
  logic out_beat = 1'b0;
  int   send_gap = 0;
  int   send_calm = 0;
  int   take_stall = 0;
  int   take_calm = 0;

  int unsigned items_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned ticks_issued = 0;
  int unsigned ticks_checked = 0;
  int unsigned notes_played = 0;
  int unsigned tails_ended = 0;
  int unsigned scale_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  sine_voice_with_release_decay_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_note         (in_note),
    .in_velocity     (in_velocity),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_voice_ended (out_voice_ended),
    .out_active      (out_active),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_phase_scale (cfg_phase_scale)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] note_freq_q10(input logic [NOTE_W-1:0] n);
    int m;
    int sh;
    m  = int'(n) + 3;
    sh = 16 - m / 12;
    return (64'(OCTAVE_Q16[m % 12]) + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [63:0] sine_magnitude(input logic [SINE_TABLE_BITS-1:0] idx,
                                                 output logic neg);
    logic [63:0] p;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] s;
    p = 64'(idx[QUARTER_BITS-1:0]);
    // Odd quadrants run the quarter wave backward, reaching the peak entry.
    if (idx[QUARTER_BITS]) begin
      p = (64'd1 << QUARTER_BITS) - p;
    end
    u  = p << (32 - SINE_TABLE_BITS);
    u2 = (u * u) >> 30;
    s  = SINE_Q30[6];
    for (int k = 5; k >= 0; k--) begin
      s = SINE_Q30[k] - ((s * u2) >> 30);
    end
    s = (s * u) >> 30;
    if (s > FULL_TURN_Q30) begin
      s = FULL_TURN_Q30;
    end
    neg = idx[SINE_TABLE_BITS-1];
    return (s * PEAK_CODE + (64'd1 << 29)) >> 30;
  endfunction

  function automatic void silence_voice();
    v_step = '0;
    v_amp  = '0;
    v_tail = '0;
  endfunction

  // Applies one accepted beat to the predicted voice; a tick also owes one result.
  function automatic void play_beat(input voice_item_t it);
    logic [63:0]            mag;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] smp;
    tick_result_t           r;
    case (it.action)
      ACT_NOTE_ON: begin
        v_phase = '0;
        v_tail  = '0;
        v_amp   = AMP_W'((64'(it.velocity) * 64'd98304 + 64'd635) / 64'd1270);
        v_step  = PHASE_BITS'((note_freq_q10(it.note) * 64'(v_scale)) >> (18 + 32 - PHASE_BITS));
        notes_played++;
      end
      ACT_RELEASE: begin
        if (v_step != '0 && v_tail == '0) begin
          v_tail = TAIL_START;
        end
      end
      ACT_STOP: begin
        silence_voice();
      end
      default: begin
        r.ended = 1'b0;
        r.sample = '0;
        r.active = 1'b0;
        if (v_step != '0) begin
          mag = sine_magnitude(v_phase[PHASE_BITS-1 -: SINE_TABLE_BITS], neg);
          if (v_tail != '0) begin
            mag = (mag * 64'(v_amp) * 64'(v_tail)) >> 32;
          end else begin
            mag = (mag * 64'(v_amp)) >> 16;
          end
          smp = SAMPLE_BITS'(mag);
          if (neg) begin
            smp = -smp;
          end
          r.sample = smp;
          v_phase = v_phase + v_step;
          if (v_tail != '0) begin
            v_tail = TAIL_W'((64'(v_tail) * TAIL_FACTOR) >> 16);
            if (v_tail <= TAIL_END_LEVEL) begin
              silence_voice();
              r.ended = 1'b1;
            end
          end
          r.active = (v_step != '0);
        end
        r.tick_no = ticks_issued;
        ticks_issued++;
        owed_ticks.push_back(r);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
    mismatches++;
  endtask

  task automatic check_tick();
    tick_result_t want;
    if (owed_ticks.size() == 0) begin
      report_mismatch($sformatf("result beat with no tick outstanding (sample %0d)", out_sample));
      return;
    end
    want = owed_ticks.pop_front();
    ticks_checked++;
    if (out_sample !== want.sample) begin
      report_mismatch($sformatf("tick %0d sample %0d, predicted %0d",
                                want.tick_no, out_sample, want.sample));
    end
    if (out_voice_ended !== want.ended) begin
      report_mismatch($sformatf("tick %0d voice_ended %b, predicted %b",
                                want.tick_no, out_voice_ended, want.ended));
    end
    if (out_active !== want.active) begin
      report_mismatch($sformatf("tick %0d active %b, predicted %b",
                                want.tick_no, out_active, want.active));
    end
    if (want.ended) begin
      tails_ended++;
    end
  endtask

  // Mostly no pause, sometimes a short or long one, and now and then a calm stretch.
  function automatic int pick_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Input and configuration beats update the predictor; result beats are checked first.
  always @(posedge clk) begin
    voice_item_t seen;
    if (rst_n) begin
      in_beat  <= in_valid && in_ready;
      out_beat <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        check_tick();
      end
      if (in_valid && in_ready) begin
        seen.action   = action_t'(in_action);
        seen.note     = in_note;
        seen.velocity = in_velocity;
        play_beat(seen);
        beats_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        v_scale = cfg_phase_scale;
        scale_writes++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_beat)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (beat_backlog.size() != 0) begin
        next_beat = beat_backlog.pop_front();
        in_action   <= next_beat.action;
        in_note     <= next_beat.note;
        in_velocity <= next_beat.velocity;
        in_valid    <= 1'b1;
        send_gap = pick_pause(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (take_stall == 0 && (out_beat || $urandom_range(0, 7) == 0)) begin
        take_stall = pick_pause(take_calm);
      end
      if (take_stall > 0) begin
        out_ready <= 1'b0;
        take_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d ticks still owed", cycle_count, owed_ticks.size());
      $display("sine_voice_with_release_decay_unit test failed");
      $finish;
    end
  end

  function automatic int rnd7();
    return $urandom_range(0, 127);
  endfunction

  task automatic queue_beat(input action_t a, input int note, input int vel);
    voice_item_t it;
    it.action   = a;
    it.note     = NOTE_W'(note);
    it.velocity = VEL_W'(vel);
    beat_backlog.push_back(it);
    items_queued++;
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_beat(ACT_TICK, rnd7(), rnd7());
  endtask

  // Note on, a few samples, then a release, a stop or a voice left ringing.
  task automatic queue_phrase();
    int ending;
    queue_beat(ACT_NOTE_ON, rnd7(), rnd7());
    queue_ticks($urandom_range(1, 24));
    ending = $urandom_range(0, 4);
    if (ending <= 1) begin
      queue_beat(ACT_RELEASE, rnd7(), rnd7());
      queue_ticks($urandom_range(1, 24));
      if (ending == 1) begin
        queue_beat(ACT_RELEASE, rnd7(), rnd7());
        queue_ticks($urandom_range(1, 6));
      end
    end
    if (ending == 2 || (ending <= 1 && $urandom_range(0, 3) == 0)) begin
      queue_beat(ACT_STOP, rnd7(), rnd7());
      queue_ticks($urandom_range(0, 3));
    end
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(1, 6)) queue_beat(action_t'($urandom_range(0, 3)), rnd7(), rnd7());
  endtask

  // A release left alone until the tail falls below its floor, then idle ticks.
  task automatic queue_full_tail();
    queue_beat(ACT_NOTE_ON, rnd7(), $urandom_range(64, 127));
    queue_ticks($urandom_range(1, 8));
    queue_beat(ACT_RELEASE, rnd7(), rnd7());
    queue_ticks(540);
  endtask

  task automatic queue_directed_beats();
    queue_beat(ACT_TICK, 127, 127);
    queue_beat(ACT_RELEASE, 0, 0);
    queue_beat(ACT_TICK, 0, 0);
    queue_beat(ACT_STOP, 127, 0);
    queue_beat(ACT_TICK, 0, 127);
    queue_beat(ACT_NOTE_ON, 0, 127);
    queue_ticks(2);
    queue_beat(ACT_NOTE_ON, 127, 127);
    queue_ticks(2);
    // A zero velocity keeps the voice running with silent samples.
    queue_beat(ACT_NOTE_ON, 69, 0);
    queue_ticks(1);
    queue_beat(ACT_NOTE_ON, 60, 100);
    queue_ticks(1);
    queue_beat(ACT_RELEASE, 0, 0);
    queue_ticks(1);
    queue_beat(ACT_RELEASE, 127, 127);
    queue_ticks(1);
    queue_beat(ACT_STOP, 0, 0);
    queue_ticks(1);
    queue_beat(ACT_NOTE_ON, 64, 1);
    queue_beat(ACT_RELEASE, 0, 0);
    // A note on during a tail restarts the voice without a tail.
    queue_beat(ACT_NOTE_ON, 72, 64);
    queue_ticks(2);
  endtask

  // Note on, release and stop beats leave no result, so allow their latency to drain.
  task automatic wait_voice_idle();
    while (beat_backlog.size() != 0 || in_valid || owed_ticks.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    @(negedge clk);
    cfg_phase_scale <= value;
    cfg_valid       <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SCALE_W-1:0] plan [7];
    int unsigned        base;
    plan[0] = SCALE_W'(5726623);
    plan[1] = SCALE_W'(137438953);
    plan[2] = '1;
    plan[3] = SCALE_W'(1);
    plan[4] = '0;
    plan[5] = SCALE_W'($urandom_range(5726623, 137438953));
    plan[6] = SCALE_W'(22906492);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_directed_beats();
    wait_voice_idle();

    for (int ph = 0; ph < 7; ph++) begin
      write_scale(plan[ph]);
      base = items_queued;
      if (ph == 5) begin
        queue_full_tail();
      end
      while (items_queued - base < PHASE_BUDGET) begin
        if ($urandom_range(0, 99) < 75) begin
          queue_phrase();
        end else begin
          queue_noise();
        end
      end
      wait_voice_idle();
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d input beats, %0d note-ons and %0d checked samples,",
             beats_taken, notes_played, ticks_checked);
    $display("with %0d completed release tails over %0d phase_scale settings; %0d mismatches.",
             tails_ended, scale_writes, mismatches);
    if (mismatches == 0 && owed_ticks.size() == 0) begin
      $display("sine_voice_with_release_decay_unit test passed");
    end else begin
      $display("sine_voice_with_release_decay_unit test failed");
    end
    $finish;
  end

endmodule
